/* rtl/core/assert_macros.svh */
// assertion macros shared by the regulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked every clock outside reset
`define LLPR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("llpr assertion failed");

// condition in this cycle implies property in the next one
`define LLPR_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("llpr assertion failed");

`endif

/* rtl/core/llpr_pkg.sv */
// types, constants and helpers of the lead/lag pi regulator
package llpr_pkg;

    localparam int SW    = 32;            // signal width, q16.16
    localparam int CW    = 20;            // coefficient width, q8.12
    localparam int CFRAC = 12;
    localparam int GW    = 24;            // integrator gain width, q0.24
    localparam int IFRAC = 24;
    localparam int LW    = 32;            // limit width
    localparam int PW    = SW + 1 + GW + 1;
    localparam int AW    = PW + 2;
    localparam int NST   = 6;

    localparam logic signed [63:0] SIG_MAX  = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [63:0] SIG_MIN  = -SIG_MAX - 64'sd1;
    localparam logic signed [63:0] Q_PI     = 64'sd205887;
    localparam logic signed [63:0] Q_TWO_PI = 64'sd411775;

    // stage numbers of the history store
    localparam logic [2:0] ST_PRE  = 3'd0;
    localparam logic [2:0] ST_FFF  = 3'd1;
    localparam logic [2:0] ST_FWD  = 3'd2;
    localparam logic [2:0] ST_FB   = 3'd3;
    localparam logic [2:0] ST_INT  = 3'd4;
    localparam logic [2:0] ST_POST = 3'd5;

    // mode register bits
    localparam int B_ON     = 0;
    localparam int B_INT    = 1;
    localparam int B_FWD    = 2;
    localparam int B_FB     = 3;
    localparam int B_PRE    = 4;
    localparam int B_POST   = 5;
    localparam int B_FF     = 6;
    localparam int B_FFF    = 7;
    localparam int B_OCLAMP = 8;
    localparam int B_DIRECT = 9;
    localparam int B_GYRO   = 10;
    localparam int B_WRAP   = 11;
    localparam int B_ICLAMP = 12;
    localparam int B_PCLAMP = 13;

    typedef enum logic [2:0] {
        REG_MODE, REG_GAIN, REG_INT, REG_POST, REG_PRE, REG_FFF, REG_FWD, REG_FB
    } t_reg_idx;

    localparam logic [47:0] RST_MODE = 48'd0;
    localparam logic [39:0] RST_GAIN = 40'd4294971392;
    localparam logic [55:0] RST_INT  = 56'd36028797002195141;
    localparam logic [59:0] RST_PZ   = 60'd0;

    typedef struct packed {
        logic signed [SW-1:0] reference;
        logic signed [SW-1:0] measured;
        logic signed [SW-1:0] rate_sample;
        logic                 clear_history;
    } t_in_item;

    typedef struct packed {
        logic signed [SW-1:0] drive;
        logic                 saturated;
    } t_out_item;

    typedef struct packed {
        logic [47:0] mode;
        logic [39:0] gain;
        logic [55:0] integ;
        logic [55:0] post;
        logic [59:0] pre;
        logic [59:0] fff;
        logic [59:0] fwd;
        logic [59:0] fb;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_FF_MUL, S_FF_ACC, S_FF_WB,
        S_PZ_MA, S_PZ_MB, S_PZ_MC, S_PZ_ACC, S_PZ_WB,
        S_GY_MUL, S_GY_ACC, S_GY_WB, S_UNWRAP, S_WRAP,
        S_ERR, S_EP_MUL, S_EP_ACC, S_EP_WB,
        S_INT_SUM, S_INT_MUL, S_INT_ACC, S_INT_WB,
        S_U1, S_U1FF, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MOP_NONE, MOP_FFGAIN, MOP_A, MOP_B, MOP_C, MOP_GYRO, MOP_PGAIN, MOP_IGAIN
    } t_mop;

    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} t_accop;

    typedef enum logic [3:0] {
        OP_NONE, OP_FF, OP_PZ, OP_GYRO, OP_UNWRAP, OP_WRAP, OP_ERR, OP_EU,
        OP_ISUM, OP_INT, OP_U1, OP_U1FF, OP_OUT
    } t_op;

    typedef struct packed {
        logic       start;
        t_mop       mop;
        t_accop     acc;
        t_op        op;
        logic [2:0] stage;
    } t_cmd;

    typedef struct packed {
        logic clamp_active;
        logic out_blocked;
    } t_status;

    function automatic logic signed [SW-1:0] sat_sig(input logic signed [63:0] v);
        if (v > SIG_MAX) return SW'(SIG_MAX);
        if (v < SIG_MIN) return SW'(SIG_MIN);
        return v[SW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] coef_field(input logic [3*CW-1:0] r,
                                                        input logic [1:0] k);
        return r[k*CW +: CW];
    endfunction

endpackage

/* rtl/core/lead_lag_pi_regulator.sv */
// top level of the lead/lag pi regulator with feed-forward
//
//   channel   direction  handshake              payload
//   in        input      i_in_valid/o_in_stall  i_in_data  (reference, measured, rate, clear)
//   out       output     o_out_valid/i_out_stall o_out_data (drive, saturated)
//   config    input      apb psel/penable       paddr[5:3] selects a 64-bit register
//
// with the controller off a tick goes straight to its output step; with stages on, each
// pole-zero stage steps through three products, accumulation and write-back, and every
// gain or integrator multiply goes through the one shared 33x25 multiplier and its accumulator.
// a new tick is taken only when the sequencer is idle; a finished result waits in the
// output register and the next tick stalls at its output step until that is taken.
// synchronous active-low reset clears histories, clamp state and the output valid.
module lead_lag_pi_regulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  llpr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output llpr_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    llpr_pkg::t_cfg    cfg;
    llpr_pkg::t_cmd    cmd;
    llpr_pkg::t_status status;

    llpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    llpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (cfg.mode),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    llpr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_status    (status)
    );

endmodule

/* rtl/core/llpr_cfg.sv */
// apb register file of the regulator
module llpr_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output llpr_pkg::t_cfg    o_cfg
);

    llpr_pkg::t_cfg   r_cfg;
    llpr_pkg::t_reg_idx idx;
    logic             wr;

    assign pready = 1'b1;
    assign idx    = llpr_pkg::t_reg_idx'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= llpr_pkg::RST_MODE;
            r_cfg.gain  <= llpr_pkg::RST_GAIN;
            r_cfg.integ <= llpr_pkg::RST_INT;
            r_cfg.post  <= llpr_pkg::RST_INT;
            r_cfg.pre   <= llpr_pkg::RST_PZ;
            r_cfg.fff   <= llpr_pkg::RST_PZ;
            r_cfg.fwd   <= llpr_pkg::RST_PZ;
            r_cfg.fb    <= llpr_pkg::RST_PZ;
        end else if (wr) begin
            case (idx)
                llpr_pkg::REG_MODE: r_cfg.mode  <= pwdata[47:0];
                llpr_pkg::REG_GAIN: r_cfg.gain  <= pwdata[39:0];
                llpr_pkg::REG_INT:  r_cfg.integ <= pwdata[55:0];
                llpr_pkg::REG_POST: r_cfg.post  <= pwdata[55:0];
                llpr_pkg::REG_PRE:  r_cfg.pre   <= pwdata[59:0];
                llpr_pkg::REG_FFF:  r_cfg.fff   <= pwdata[59:0];
                llpr_pkg::REG_FWD:  r_cfg.fwd   <= pwdata[59:0];
                llpr_pkg::REG_FB:   r_cfg.fb    <= pwdata[59:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            llpr_pkg::REG_MODE: prdata = {16'd0, r_cfg.mode};
            llpr_pkg::REG_GAIN: prdata = {24'd0, r_cfg.gain};
            llpr_pkg::REG_INT:  prdata = {8'd0, r_cfg.integ};
            llpr_pkg::REG_POST: prdata = {8'd0, r_cfg.post};
            llpr_pkg::REG_PRE:  prdata = {4'd0, r_cfg.pre};
            llpr_pkg::REG_FFF:  prdata = {4'd0, r_cfg.fff};
            llpr_pkg::REG_FWD:  prdata = {4'd0, r_cfg.fwd};
            llpr_pkg::REG_FB:   prdata = {4'd0, r_cfg.fb};
            default:            prdata = 64'd0;
        endcase
    end

endmodule

/* rtl/core/llpr_ctrl.sv */
// sequencer that walks one tick through the enabled stages
`include "assert_macros.svh"

module llpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [47:0]       i_mode,
    input  llpr_pkg::t_status i_status,
    output llpr_pkg::t_cmd    o_cmd
);

    llpr_pkg::t_state r_state, n_state;
    logic [2:0]       r_stage, n_stage;
    logic             accept;

    // branch targets after each optional stage
    llpr_pkg::t_state s_ff, s_pre, s_back, s_eu;
    logic [2:0]       g_ff, g_pre, g_back, g_eu;

    assign o_in_stall = (r_state != llpr_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llpr_pkg::S_IDLE;
            r_stage <= llpr_pkg::ST_PRE;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    always_comb begin
        // integrator or frozen pass-through
        if (i_mode[llpr_pkg::B_INT] && !i_status.clamp_active) begin
            s_eu = llpr_pkg::S_INT_SUM;
            g_eu = llpr_pkg::ST_INT;
        end else begin
            s_eu = llpr_pkg::S_U1;
            g_eu = r_stage;
        end
        s_back = i_mode[llpr_pkg::B_WRAP] ? llpr_pkg::S_WRAP : llpr_pkg::S_ERR;
        g_back = r_stage;
        if (i_mode[llpr_pkg::B_FB]) begin
            s_pre = i_mode[llpr_pkg::B_GYRO] ? llpr_pkg::S_GY_MUL : llpr_pkg::S_UNWRAP;
            g_pre = r_stage;
        end else begin
            s_pre = s_back;
            g_pre = g_back;
        end
        if (i_mode[llpr_pkg::B_PRE]) begin
            s_ff = llpr_pkg::S_PZ_MA;
            g_ff = llpr_pkg::ST_PRE;
        end else begin
            s_ff = s_pre;
            g_ff = g_pre;
        end

        n_state   = r_state;
        n_stage   = r_stage;
        o_cmd     = '0;
        o_cmd.start = accept;
        o_cmd.stage = r_stage;
        o_cmd.mop   = llpr_pkg::MOP_NONE;
        o_cmd.acc   = llpr_pkg::ACC_HOLD;
        o_cmd.op    = llpr_pkg::OP_NONE;

        case (r_state)
            llpr_pkg::S_IDLE: begin
                if (accept) begin
                    if (!i_mode[llpr_pkg::B_ON]) begin
                        n_state = llpr_pkg::S_OUT;
                    end else if (i_mode[llpr_pkg::B_FF]) begin
                        n_state = llpr_pkg::S_FF_MUL;
                    end else begin
                        n_state = s_ff;
                        n_stage = g_ff;
                    end
                end
            end
            llpr_pkg::S_FF_MUL: begin
                o_cmd.mop = llpr_pkg::MOP_FFGAIN;
                n_state   = llpr_pkg::S_FF_ACC;
            end
            llpr_pkg::S_FF_ACC: begin
                o_cmd.acc = llpr_pkg::ACC_LOAD;
                n_state   = llpr_pkg::S_FF_WB;
            end
            llpr_pkg::S_FF_WB: begin
                o_cmd.op = llpr_pkg::OP_FF;
                if (i_mode[llpr_pkg::B_FFF]) begin
                    n_state = llpr_pkg::S_PZ_MA;
                    n_stage = llpr_pkg::ST_FFF;
                end else begin
                    n_state = s_ff;
                    n_stage = g_ff;
                end
            end
            llpr_pkg::S_PZ_MA: begin
                o_cmd.mop = llpr_pkg::MOP_A;
                n_state   = llpr_pkg::S_PZ_MB;
            end
            llpr_pkg::S_PZ_MB: begin
                o_cmd.mop = llpr_pkg::MOP_B;
                o_cmd.acc = llpr_pkg::ACC_LOAD;
                n_state   = llpr_pkg::S_PZ_MC;
            end
            llpr_pkg::S_PZ_MC: begin
                o_cmd.mop = llpr_pkg::MOP_C;
                o_cmd.acc = llpr_pkg::ACC_ADD;
                n_state   = llpr_pkg::S_PZ_ACC;
            end
            llpr_pkg::S_PZ_ACC: begin
                o_cmd.acc = llpr_pkg::ACC_ADD;
                n_state   = llpr_pkg::S_PZ_WB;
            end
            llpr_pkg::S_PZ_WB: begin
                o_cmd.op = llpr_pkg::OP_PZ;
                case (r_stage)
                    llpr_pkg::ST_FFF: begin
                        n_state = s_ff;
                        n_stage = g_ff;
                    end
                    llpr_pkg::ST_PRE: begin
                        n_state = s_pre;
                        n_stage = g_pre;
                    end
                    llpr_pkg::ST_FB: begin
                        n_state = s_back;
                        n_stage = g_back;
                    end
                    default: begin
                        n_state = s_eu;
                        n_stage = g_eu;
                    end
                endcase
            end
            llpr_pkg::S_GY_MUL: begin
                o_cmd.mop = llpr_pkg::MOP_GYRO;
                n_state   = llpr_pkg::S_GY_ACC;
            end
            llpr_pkg::S_GY_ACC: begin
                o_cmd.acc = llpr_pkg::ACC_LOAD;
                n_state   = llpr_pkg::S_GY_WB;
            end
            llpr_pkg::S_GY_WB: begin
                o_cmd.op = llpr_pkg::OP_GYRO;
                n_state  = s_back;
                n_stage  = g_back;
            end
            llpr_pkg::S_UNWRAP: begin
                o_cmd.op = llpr_pkg::OP_UNWRAP;
                n_state  = llpr_pkg::S_PZ_MA;
                n_stage  = llpr_pkg::ST_FB;
            end
            llpr_pkg::S_WRAP: begin
                o_cmd.op = llpr_pkg::OP_WRAP;
                n_state  = llpr_pkg::S_ERR;
            end
            llpr_pkg::S_ERR: begin
                o_cmd.op = llpr_pkg::OP_ERR;
                n_state  = llpr_pkg::S_EP_MUL;
            end
            llpr_pkg::S_EP_MUL: begin
                o_cmd.mop = llpr_pkg::MOP_PGAIN;
                n_state   = llpr_pkg::S_EP_ACC;
            end
            llpr_pkg::S_EP_ACC: begin
                o_cmd.acc = llpr_pkg::ACC_LOAD;
                n_state   = llpr_pkg::S_EP_WB;
            end
            llpr_pkg::S_EP_WB: begin
                o_cmd.op = llpr_pkg::OP_EU;
                if (i_mode[llpr_pkg::B_FWD]) begin
                    n_state = llpr_pkg::S_PZ_MA;
                    n_stage = llpr_pkg::ST_FWD;
                end else begin
                    n_state = s_eu;
                    n_stage = g_eu;
                end
            end
            llpr_pkg::S_INT_SUM: begin
                o_cmd.op = llpr_pkg::OP_ISUM;
                n_state  = llpr_pkg::S_INT_MUL;
            end
            llpr_pkg::S_INT_MUL: begin
                o_cmd.mop = llpr_pkg::MOP_IGAIN;
                n_state   = llpr_pkg::S_INT_ACC;
            end
            llpr_pkg::S_INT_ACC: begin
                o_cmd.acc = llpr_pkg::ACC_LOAD;
                n_state   = llpr_pkg::S_INT_WB;
            end
            llpr_pkg::S_INT_WB: begin
                o_cmd.op = llpr_pkg::OP_INT;
                n_state  = (r_stage == llpr_pkg::ST_INT) ? llpr_pkg::S_U1FF
                                                         : llpr_pkg::S_OUT;
            end
            llpr_pkg::S_U1: begin
                o_cmd.op = llpr_pkg::OP_U1;
                n_state  = llpr_pkg::S_U1FF;
            end
            llpr_pkg::S_U1FF: begin
                o_cmd.op = llpr_pkg::OP_U1FF;
                if (i_mode[llpr_pkg::B_POST]) begin
                    n_state = llpr_pkg::S_INT_SUM;
                    n_stage = llpr_pkg::ST_POST;
                end else begin
                    n_state = llpr_pkg::S_OUT;
                end
            end
            llpr_pkg::S_OUT: begin
                // hold here while the previous result still waits
                if (!i_status.out_blocked) begin
                    o_cmd.op = llpr_pkg::OP_OUT;
                    n_state  = llpr_pkg::S_IDLE;
                end
            end
            default: n_state = llpr_pkg::S_IDLE;
        endcase
    end

    `LLPR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != llpr_pkg::S_IDLE)
    `LLPR_ASSERT(a_pz_stage, i_clk, i_rst_n, (r_state == llpr_pkg::S_PZ_MA) |-> (r_stage <= llpr_pkg::ST_FB))
    `LLPR_ASSERT(a_int_stage, i_clk, i_rst_n, (r_state == llpr_pkg::S_INT_SUM) |-> (r_stage == llpr_pkg::ST_INT || r_stage == llpr_pkg::ST_POST))

endmodule

/* rtl/core/llpr_dp.sv */
// datapath: shared multiplier, accumulator, stage histories and output register
`include "assert_macros.svh"

module llpr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  llpr_pkg::t_cmd      i_cmd,
    input  llpr_pkg::t_cfg      i_cfg,
    input  llpr_pkg::t_in_item  i_in_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output llpr_pkg::t_out_item o_out_data,
    output llpr_pkg::t_status   o_status
);

    localparam int SW = llpr_pkg::SW;
    localparam int CW = llpr_pkg::CW;
    localparam int GW = llpr_pkg::GW;
    localparam int LW = llpr_pkg::LW;
    localparam int PW = llpr_pkg::PW;
    localparam int AW = llpr_pkg::AW;

    logic signed [SW-1:0] r_ref, r_meas, r_rate, r_ff, r_pre, r_back, r_eu, r_u1, r_u;
    logic signed [SW:0]   r_sum;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_hx [llpr_pkg::NST];
    logic signed [SW-1:0] r_hy [llpr_pkg::NST];
    logic                 r_clamp;
    logic                 r_out_valid;
    llpr_pkg::t_out_item  r_out;

    logic signed [SW-1:0] hx_s, hy_s, x0_s;
    logic [3*CW-1:0]      cset;
    logic [55:0]          iset;
    logic signed [CW-1:0] ca1, cb0, cb1, kp, kff, kgy;
    logic [GW-1:0]        ig;
    logic [LW-1:0]        ilim;
    logic                 iclamp_en;
    logic signed [SW:0]   mx;
    logic signed [GW:0]   mc;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] acc_ext, pz_shift, int_shift;
    logic signed [SW-1:0] pz_y, int_raw, int_y, gyro_back, err, u1_frozen, u1_ff, eu_int;
    logic signed [SW-1:0] post_out;
    logic signed [SW+1:0] int_y_ext, ilim_ext, u_ext, olim_ext;
    logic signed [63:0]   d_fb, d_ref;
    logic signed [SW-1:0] fb_hx, fb_hy, pre_wrapped;
    logic signed [SW-1:0] out_drive;
    logic                 out_hit;
    logic                 fb_move;

    always_comb begin
        case (i_cmd.stage)
            llpr_pkg::ST_PRE:  begin hx_s = r_hx[0]; hy_s = r_hy[0]; x0_s = r_ref; end
            llpr_pkg::ST_FFF:  begin hx_s = r_hx[1]; hy_s = r_hy[1]; x0_s = r_ff;  end
            llpr_pkg::ST_FWD:  begin hx_s = r_hx[2]; hy_s = r_hy[2]; x0_s = r_eu;  end
            llpr_pkg::ST_FB:   begin hx_s = r_hx[3]; hy_s = r_hy[3]; x0_s = r_meas; end
            llpr_pkg::ST_INT:  begin hx_s = r_hx[4]; hy_s = r_hy[4]; x0_s = r_eu;  end
            llpr_pkg::ST_POST: begin hx_s = r_hx[5]; hy_s = r_hy[5]; x0_s = r_u1;  end
            default:           begin hx_s = '0;      hy_s = '0;      x0_s = '0;    end
        endcase
        case (i_cmd.stage)
            llpr_pkg::ST_PRE: cset = i_cfg.pre;
            llpr_pkg::ST_FFF: cset = i_cfg.fff;
            llpr_pkg::ST_FWD: cset = i_cfg.fwd;
            default:          cset = i_cfg.fb;
        endcase
        iset      = (i_cmd.stage == llpr_pkg::ST_INT) ? i_cfg.integ : i_cfg.post;
        iclamp_en = (i_cmd.stage == llpr_pkg::ST_INT) ? i_cfg.mode[llpr_pkg::B_ICLAMP]
                                                      : i_cfg.mode[llpr_pkg::B_PCLAMP];
    end

    assign ca1  = llpr_pkg::coef_field(cset, 2'd0);
    assign cb0  = llpr_pkg::coef_field(cset, 2'd1);
    assign cb1  = llpr_pkg::coef_field(cset, 2'd2);
    assign kgy  = llpr_pkg::coef_field(i_cfg.fb, 2'd1);
    assign kp   = i_cfg.gain[CW-1:0];
    assign kff  = i_cfg.gain[2*CW-1:CW];
    assign ig   = iset[GW-1:0];
    assign ilim = iset[GW+LW-1:GW];

    // operand select of the shared multiplier
    always_comb begin
        case (i_cmd.mop)
            llpr_pkg::MOP_FFGAIN: begin mx = (SW+1)'(r_ref);  mc = (GW+1)'(kff); end
            llpr_pkg::MOP_A:      begin mx = (SW+1)'(hy_s);   mc = -((GW+1)'(ca1)); end
            llpr_pkg::MOP_B:      begin mx = (SW+1)'(x0_s);   mc = (GW+1)'(cb0); end
            llpr_pkg::MOP_C:      begin mx = (SW+1)'(hx_s);   mc = (GW+1)'(cb1); end
            llpr_pkg::MOP_GYRO:   begin mx = (SW+1)'(r_rate); mc = (GW+1)'(kgy); end
            llpr_pkg::MOP_PGAIN:  begin mx = r_sum;           mc = (GW+1)'(kp);  end
            llpr_pkg::MOP_IGAIN:  begin mx = r_sum;           mc = {1'b0, ig};   end
            default:              begin mx = '0;              mc = '0;           end
        endcase
    end

    assign prod      = PW'(mx) * PW'(mc);
    assign acc_ext   = AW'(r_prod);
    assign pz_shift  = r_acc >>> llpr_pkg::CFRAC;
    assign int_shift = r_acc >>> llpr_pkg::IFRAC;
    assign pz_y      = llpr_pkg::sat_sig(64'(pz_shift));

    // trapezoid integrator with optional clamp
    assign int_raw   = llpr_pkg::sat_sig(64'(hy_s) + 64'(int_shift));
    assign int_y_ext = (SW+2)'(int_raw);
    assign ilim_ext  = (SW+2)'({2'b00, ilim});
    always_comb begin
        int_y = int_raw;
        if (iclamp_en && int_y_ext > ilim_ext) begin
            int_y = ilim_ext[SW-1:0];
        end else if (iclamp_en && int_y_ext < -ilim_ext) begin
            int_y = SW'(-ilim_ext);
        end
    end

    assign gyro_back = llpr_pkg::sat_sig(64'(r_meas) + 64'(pz_y));
    assign err       = llpr_pkg::sat_sig(64'(r_pre) - 64'(r_back));
    assign eu_int    = llpr_pkg::sat_sig(64'(r_eu) + 64'(int_y));
    assign u1_frozen = i_cfg.mode[llpr_pkg::B_INT]
                       ? llpr_pkg::sat_sig(64'(r_eu) + 64'(r_hy[4])) : r_eu;
    assign u1_ff     = llpr_pkg::sat_sig(64'(r_u1) + 64'(r_ff));
    assign post_out  = i_cfg.mode[llpr_pkg::B_DIRECT]
                       ? llpr_pkg::sat_sig(64'(r_u1) + 64'(int_y)) : int_y;

    // feedback history unwrap by a full turn
    always_comb begin
        d_fb    = 64'(r_meas) - 64'(r_hx[3]);
        fb_move = 1'b0;
        fb_hx   = r_hx[3];
        fb_hy   = r_hy[3];
        if (d_fb > llpr_pkg::Q_PI) begin
            fb_move = 1'b1;
            fb_hx   = llpr_pkg::sat_sig(64'(r_hx[3]) + llpr_pkg::Q_TWO_PI);
            fb_hy   = llpr_pkg::sat_sig(64'(r_hy[3]) + llpr_pkg::Q_TWO_PI);
        end else if (d_fb < -llpr_pkg::Q_PI) begin
            fb_move = 1'b1;
            fb_hx   = llpr_pkg::sat_sig(64'(r_hx[3]) - llpr_pkg::Q_TWO_PI);
            fb_hy   = llpr_pkg::sat_sig(64'(r_hy[3]) - llpr_pkg::Q_TWO_PI);
        end
    end

    // reference wrap into +-pi of the measurement
    always_comb begin
        d_ref       = 64'(r_pre) - 64'(r_meas);
        pre_wrapped = r_pre;
        if (d_ref > llpr_pkg::Q_PI) begin
            pre_wrapped = llpr_pkg::sat_sig(64'(r_pre) - llpr_pkg::Q_TWO_PI);
        end else if (d_ref < -llpr_pkg::Q_PI) begin
            pre_wrapped = llpr_pkg::sat_sig(64'(r_pre) + llpr_pkg::Q_TWO_PI);
        end
    end

    // output clamp
    assign u_ext    = (SW+2)'(r_u);
    assign olim_ext = (SW+2)'({2'b00, i_cfg.mode[47:16]});
    always_comb begin
        out_drive = r_u;
        out_hit   = 1'b0;
        if (!i_cfg.mode[llpr_pkg::B_ON]) begin
            out_drive = '0;
        end else if (i_cfg.mode[llpr_pkg::B_OCLAMP]) begin
            if (u_ext > olim_ext) begin
                out_drive = olim_ext[SW-1:0];
                out_hit   = 1'b1;
            end else if (u_ext < -olim_ext) begin
                out_drive = SW'(-olim_ext);
                out_hit   = 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        case (i_cmd.acc)
            llpr_pkg::ACC_LOAD: r_acc <= acc_ext;
            llpr_pkg::ACC_ADD:  r_acc <= r_acc + acc_ext;
            default: ;
        endcase
        if (i_cmd.start) begin
            r_ref  <= i_in_data.reference;
            r_meas <= i_in_data.measured;
            r_rate <= i_in_data.rate_sample;
            r_pre  <= i_in_data.reference;
            r_back <= i_in_data.measured;
            r_ff   <= '0;
        end
        case (i_cmd.op)
            llpr_pkg::OP_FF:   r_ff <= pz_y;
            llpr_pkg::OP_PZ: begin
                case (i_cmd.stage)
                    llpr_pkg::ST_PRE: r_pre  <= pz_y;
                    llpr_pkg::ST_FFF: r_ff   <= pz_y;
                    llpr_pkg::ST_FWD: r_eu   <= pz_y;
                    default:          r_back <= pz_y;
                endcase
            end
            llpr_pkg::OP_GYRO: r_back <= gyro_back;
            llpr_pkg::OP_WRAP: r_pre  <= pre_wrapped;
            llpr_pkg::OP_ERR:  r_sum  <= (SW+1)'(err);
            llpr_pkg::OP_EU:   r_eu   <= pz_y;
            llpr_pkg::OP_ISUM: r_sum  <= (SW+1)'(x0_s) + (SW+1)'(hx_s);
            llpr_pkg::OP_INT: begin
                if (i_cmd.stage == llpr_pkg::ST_INT) begin
                    r_u1 <= eu_int;
                end else begin
                    r_u  <= post_out;
                end
            end
            llpr_pkg::OP_U1:   r_u1 <= u1_frozen;
            llpr_pkg::OP_U1FF: begin
                r_u1 <= u1_ff;
                r_u  <= u1_ff;
            end
            llpr_pkg::OP_OUT: begin
                r_out.drive     <= out_drive;
                r_out.saturated <= out_hit;
            end
            default: ;
        endcase
    end

    // stage histories and clamp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < llpr_pkg::NST; i++) begin
                r_hx[i] <= '0;
                r_hy[i] <= '0;
            end
            r_clamp     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start && i_in_data.clear_history) begin
                for (int i = 0; i < llpr_pkg::NST; i++) begin
                    r_hx[i] <= '0;
                    r_hy[i] <= '0;
                end
            end
            for (int i = 0; i < llpr_pkg::NST; i++) begin
                if (i_cmd.stage == 3'(i)) begin
                    if (i_cmd.op == llpr_pkg::OP_PZ) begin
                        r_hx[i] <= x0_s;
                        r_hy[i] <= pz_y;
                    end else if (i_cmd.op == llpr_pkg::OP_INT) begin
                        r_hx[i] <= x0_s;
                        r_hy[i] <= int_y;
                    end
                end
            end
            if (i_cmd.op == llpr_pkg::OP_UNWRAP && fb_move) begin
                r_hx[3] <= fb_hx;
                r_hy[3] <= fb_hy;
            end
            if (i_cmd.op == llpr_pkg::OP_OUT) begin
                if (i_cfg.mode[llpr_pkg::B_ON]) begin
                    r_clamp <= out_hit;
                end
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out;
    assign o_status.clamp_active = r_clamp;
    assign o_status.out_blocked  = r_out_valid && i_out_stall;

    `LLPR_ASSERT_NEXT(a_clamp_only_at_out, i_clk, i_rst_n, i_cmd.op != llpr_pkg::OP_OUT, $stable(r_clamp))

endmodule
